// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the buffer pool RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define CBBP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cbbp assertion failed");
// expression must never be true outside reset
`define CBBP_NEVER(label, clk, rst, expr) `CBBP_ASSERT(label, clk, rst, !(expr))
`else
`define CBBP_ASSERT(label, clk, rst, prop)
`define CBBP_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/core/cbbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbbp_pkg
// Sizes, codes and beat types of the chained block buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package cbbp_pkg;

  localparam int NUM_BLOCKS        = 16;
  localparam int BLOCK_OFFSET_BITS = 2;
  localparam int BLOCK_SIZE        = 1 << BLOCK_OFFSET_BITS;
  localparam int POOL_BYTES        = NUM_BLOCKS * BLOCK_SIZE;
  localparam int MAX_OUT           = 64;
  localparam int READ_LIMIT        = (POOL_BYTES < MAX_OUT) ? POOL_BYTES : MAX_OUT;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int OFF_W  = BLOCK_OFFSET_BITS;
  localparam int ADDR_W = BLK_W + OFF_W;
  localparam int LINK_W = BLK_W + 1;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;
  localparam int RCNT_W = $clog2(READ_LIMIT + 1);

  // end of chain: first code past the block range
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);
  localparam logic [OFF_W-1:0]  OFF_LAST = OFF_W'(BLOCK_SIZE - 1);

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_READ   = 2'd2
  } kind_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_NO_BLOCKS = 2'd2
  } status_e_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic [LEN_W-1:0]   msg_length;
    logic [BYTE_W-1:0]  data_byte;
    logic [BLK_W-1:0]   first_block;
  } cmd_beat_t;

  typedef struct packed {
    kind_e_t            kind;
    status_e_t          status;
    logic [BLK_W-1:0]   chain_start;
    logic [CNT_W-1:0]   free_blocks;
    logic [BYTE_W-1:0]  byte_out;
    logic               last;
  } rsp_beat_t;

  function automatic logic [BLK_W-1:0] ring_next(input logic [BLK_W-1:0] p);
    return (p == BLK_W'(NUM_BLOCKS - 1)) ? '0 : BLK_W'(p + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbbp_ram.sv =====
// ----------------------------------------------------------------------------
// cbbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/chained_block_buffer_pool_unit.sv =====
// ----------------------------------------------------------------------------
// chained_block_buffer_pool_unit
// Pool of fixed-size byte blocks with a free-block ring and chained messages.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low. Every
// result sits on the result port for exactly one cycle with valid high; the
// receiver cannot hold it off, so it must take each beat as it comes. A read
// delivers its bytes one beat at a time, the final one flagged with last.
// States per command; every memory read port is registered:
//   data byte : written from idle, then ST_D_LINK when it closes a block
//   create    : answered from idle when refused, else CR_RD, CR_LINK per block, CR_END
//   free      : FR_CHK, FR_WAIT per block returned, then a last FR_CHK
//   read      : RD_CHK, RD_OUT per byte emitted
// State lives in three RAMs: the free ring (16 x 4), the next-link table
// (16 x 5, end-of-chain code is 16) and the byte store (64 x 8). The ring
// comes out of reset holding k at slot k through one valid flop per slot, so
// there is no clearing pass and a command is taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chained_block_buffer_pool_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  cbbp_pkg::cmd_beat_t   command,
  output logic                  busy,
  output logic                  valid,
  output cbbp_pkg::rsp_beat_t   result
);

  import cbbp_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CR_RD   = 9'b000000010,  // read ring slot at head
    ST_CR_LINK = 9'b000000100,  // link previous block to the popped one
    ST_CR_END  = 9'b000001000,  // terminate chain, answer
    ST_FR_CHK  = 9'b000010000,  // push block to ring tail, fetch its link
    ST_FR_WAIT = 9'b000100000,
    ST_RD_CHK  = 9'b001000000,  // fetch byte and link of current block
    ST_RD_OUT  = 9'b010000000,  // emit byte
    ST_D_LINK  = 9'b100000000   // data write crossed a block end
  } state_t;

  state_t state;

  // pool bookkeeping
  logic [BLK_W-1:0]      ring_head;
  logic [BLK_W-1:0]      ring_tail;
  logic [CNT_W-1:0]      free_total;
  logic [NUM_BLOCKS-1:0] ring_valid;   // slot rewritten since reset

  // fill pointer for data beats
  logic [BLK_W-1:0]      write_block;
  logic [OFF_W-1:0]      write_offset;
  logic [LEN_W-1:0]      bytes_pending;

  // per-command working registers
  logic [LINK_W-1:0]     cur;
  logic [CNT_W-1:0]      need;
  logic [CNT_W-1:0]      taken;
  logic [CNT_W-1:0]      steps;
  logic [LEN_W-1:0]      len_q;
  logic [BLK_W-1:0]      chain_head;
  logic [BLK_W-1:0]      ring_pos;
  logic                  ring_hit;
  logic [RCNT_W-1:0]     limit;
  logic [RCNT_W-1:0]     cnt;
  logic [OFF_W-1:0]      off;

  // RAM ports
  logic                  ring_we, ring_re;
  logic [BLK_W-1:0]      ring_waddr, ring_raddr, ring_wdata, ring_rdata;
  logic                  link_we, link_re;
  logic [BLK_W-1:0]      link_waddr, link_raddr;
  logic [LINK_W-1:0]     link_wdata, link_rdata;
  logic                  byte_we, byte_re;
  logic [ADDR_W-1:0]     byte_waddr, byte_raddr;
  logic [BYTE_W-1:0]     byte_wdata, byte_rdata;

  cbbp_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rdata)
  );

  cbbp_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  cbbp_ram #(.WIDTH(BYTE_W), .DEPTH(POOL_BYTES)) u_bytes (
    .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .re(byte_re), .raddr(byte_raddr), .rdata(byte_rdata)
  );

  // decode of the incoming beat
  logic              accept;
  logic              too_long;
  logic [LEN_W:0]    need_wide;
  logic [CNT_W-1:0]  need_in;
  logic [RCNT_W-1:0] limit_in;
  logic              data_hit;

  // walk conditions
  logic [BLK_W-1:0]  tail_inc;
  logic [BLK_W-1:0]  popped;
  logic              free_go;
  logic              read_go;
  logic [LINK_W-1:0] rd_next_cur;
  logic              rd_done;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign too_long = 32'(command.msg_length) > POOL_BYTES;
  // blocks needed: ceil(len / size), at least one
  assign need_wide = ({1'b0, command.msg_length} + (LEN_W + 1)'(BLOCK_SIZE - 1))
                     >> BLOCK_OFFSET_BITS;
  assign need_in  = (need_wide == '0) ? CNT_W'(1) : need_wide[CNT_W-1:0];
  assign limit_in = (32'(command.msg_length) > READ_LIMIT) ? RCNT_W'(READ_LIMIT)
                                                           : RCNT_W'(command.msg_length);
  assign data_hit = accept && (command.cmd == CMD_DATA) && (bytes_pending != '0);

  assign tail_inc = ring_next(ring_tail);
  // untouched ring slots still hold their own index
  assign popped   = ring_hit ? ring_rdata : ring_pos;
  assign free_go  = !cur[BLK_W] && (free_total < CNT_W'(NUM_BLOCKS))
                    && (steps < CNT_W'(NUM_BLOCKS));
  assign read_go  = (cnt < limit) && !cur[BLK_W];
  assign rd_next_cur = (off == OFF_LAST) ? link_rdata : cur;
  assign rd_done  = (RCNT_W'(cnt + 1'b1) == limit) || rd_next_cur[BLK_W];

  function automatic rsp_beat_t make_rsp(input kind_e_t k, input status_e_t s,
                                         input logic [BLK_W-1:0] cs,
                                         input logic [CNT_W-1:0] fb,
                                         input logic [BYTE_W-1:0] b, input logic l);
    rsp_beat_t r;
    r.kind        = k;
    r.status      = s;
    r.chain_start = cs;
    r.free_blocks = fb;
    r.byte_out    = b;
    r.last        = l;
    return r;
  endfunction

  // memory port steering
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = tail_inc;
    ring_wdata = cur[BLK_W-1:0];
    ring_re    = 1'b0;
    ring_raddr = ring_head;
    link_we    = 1'b0;
    link_waddr = cur[BLK_W-1:0];
    link_wdata = {1'b0, popped};
    link_re    = 1'b0;
    link_raddr = cur[BLK_W-1:0];
    byte_we    = 1'b0;
    byte_waddr = {write_block, write_offset};
    byte_wdata = command.data_byte;
    byte_re    = 1'b0;
    byte_raddr = {cur[BLK_W-1:0], off};
    case (state)
      ST_IDLE: begin
        if (data_hit) begin
          byte_we = 1'b1;
          if (write_offset == OFF_LAST) begin
            link_re    = 1'b1;
            link_raddr = write_block;
          end
        end
      end
      ST_CR_RD: begin
        ring_re = 1'b1;
      end
      ST_CR_LINK: begin
        // the head block has no predecessor to link
        link_we = (taken != CNT_W'(1));
      end
      ST_CR_END: begin
        link_we    = 1'b1;
        link_wdata = LINK_END;
      end
      ST_FR_CHK: begin
        ring_we = free_go;
        link_re = free_go;
      end
      ST_RD_CHK: begin
        byte_re = read_go;
        link_re = read_go;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ring_head     <= '0;
      ring_tail     <= BLK_W'(NUM_BLOCKS - 1);
      free_total    <= CNT_W'(NUM_BLOCKS);
      ring_valid    <= '0;
      write_block   <= '0;
      write_offset  <= '0;
      bytes_pending <= '0;
      valid         <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command.cmd)
              CMD_CREATE: begin
                if (too_long) begin
                  valid  <= 1'b1;
                  result <= make_rsp(KIND_CREATE, ST_TOO_LONG, '0, free_total, '0, 1'b1);
                end else if (need_in > free_total) begin
                  valid  <= 1'b1;
                  result <= make_rsp(KIND_CREATE, ST_NO_BLOCKS, '0, free_total, '0, 1'b1);
                end else begin
                  need  <= need_in;
                  taken <= '0;
                  len_q <= command.msg_length;
                  state <= ST_CR_RD;
                end
              end
              CMD_DATA: begin
                // stray beat with nothing pending is dropped
                if (bytes_pending != '0) begin
                  bytes_pending <= bytes_pending - 1'b1;
                  write_offset  <= OFF_W'(write_offset + 1'b1);
                  if (write_offset == OFF_LAST) begin
                    state <= ST_D_LINK;
                  end
                end
              end
              CMD_FREE: begin
                cur   <= {1'b0, command.first_block};
                steps <= '0;
                state <= ST_FR_CHK;
              end
              CMD_READ: begin
                cur   <= {1'b0, command.first_block};
                cnt   <= '0;
                off   <= '0;
                limit <= limit_in;
                if (limit_in != '0) begin
                  state <= ST_RD_CHK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_D_LINK: begin
          if (link_rdata[BLK_W]) begin
            bytes_pending <= '0;
          end else begin
            write_block <= link_rdata[BLK_W-1:0];
          end
          state <= ST_IDLE;
        end
        ST_CR_RD: begin
          ring_pos   <= ring_head;
          ring_hit   <= ring_valid[ring_head];
          ring_head  <= ring_next(ring_head);
          free_total <= free_total - 1'b1;
          taken      <= CNT_W'(taken + 1'b1);
          state      <= ST_CR_LINK;
        end
        ST_CR_LINK: begin
          if (taken == CNT_W'(1)) begin
            chain_head <= popped;
          end
          cur   <= {1'b0, popped};
          state <= (taken == need) ? ST_CR_END : ST_CR_RD;
        end
        ST_CR_END: begin
          // a successful create drops whatever was left of the last message
          write_block   <= chain_head;
          write_offset  <= '0;
          bytes_pending <= len_q;
          valid         <= 1'b1;
          result        <= make_rsp(KIND_CREATE, ST_OK, chain_head,
                                    CNT_W'(free_total), '0, 1'b1);
          state         <= ST_IDLE;
        end
        ST_FR_CHK: begin
          if (free_go) begin
            ring_tail            <= tail_inc;
            ring_valid[tail_inc] <= 1'b1;
            free_total           <= CNT_W'(free_total + 1'b1);
            steps                <= CNT_W'(steps + 1'b1);
            state                <= ST_FR_WAIT;
          end else begin
            valid  <= 1'b1;
            result <= make_rsp(KIND_FREE, ST_OK, '0, free_total, '0, 1'b1);
            state  <= ST_IDLE;
          end
        end
        ST_FR_WAIT: begin
          cur   <= link_rdata;
          state <= ST_FR_CHK;
        end
        ST_RD_CHK: begin
          state <= read_go ? ST_RD_OUT : ST_IDLE;
        end
        ST_RD_OUT: begin
          valid  <= 1'b1;
          result <= make_rsp(KIND_READ, ST_OK, '0, '0, byte_rdata, rd_done);
          cnt    <= RCNT_W'(cnt + 1'b1);
          off    <= OFF_W'(off + 1'b1);
          cur    <= rd_next_cur;
          state  <= rd_done ? ST_IDLE : ST_RD_CHK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // free count never passes the pool size
  `CBBP_NEVER(a_free_bound, clk, rst, free_total > CNT_W'(NUM_BLOCKS))
  // ring occupancy between head and tail matches the free count
  `CBBP_ASSERT(a_ring_count, clk, rst, BLK_W'(ring_tail + 1'b1 - ring_head) == free_total[BLK_W-1:0])
  // a read byte that is not the last leaves the walk running
  `CBBP_ASSERT(a_mid_read_busy, clk, rst, valid && !result.last |-> busy)
  // chain is closed only once every needed block is popped
  `CBBP_ASSERT(a_chain_len, clk, rst, state == ST_CR_END |-> taken == need)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chained_block_buffer_pool_unit. A directed table of
// create, data, read and free beats runs first. Random message traffic
// follows: well-formed create/fill/read/free sequences with random content,
// mixed with stray bytes, odd lengths and double frees. Every result beat is
// compared field by field against the pool model or a typed row's answer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbbp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 200000;
  // counted (non-ignored) command beats to reach before the run winds down
  localparam int TARGET_BEATS = 250;
  // quiet time at the end: longer than the slowest read
  localparam int DRAIN_CYCLES = 2 * MAX_OUT + 40;

  localparam rsp_beat_t UNTYPED = '0;

  typedef struct packed {
    cmd_beat_t beat;
    logic      typed;
    rsp_beat_t want;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      valid;
  cmd_beat_t command;
  rsp_beat_t result;

  chained_block_buffer_pool_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .valid   (valid),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Pool model state: free ring, next links, byte store, fill pointer.
  // The written/linked flags track which store entries hold defined data, so
  // that the stimulus never walks into memory that was never written.
  // --------------------------------------------------------------------------
  logic [BLK_W-1:0]  ring_q    [NUM_BLOCKS];
  logic [LINK_W-1:0] link_q    [NUM_BLOCKS];
  logic [BYTE_W-1:0] store_q   [POOL_BYTES];
  bit                linked_q  [NUM_BLOCKS];
  bit                written_q [POOL_BYTES];
  int                ring_rd;
  int                ring_wr;
  int                free_cnt;
  int                fill_blk;
  int                fill_off;
  int                fill_left;

  rsp_beat_t step_beats[$];     // results of the command just taken
  rsp_beat_t awaited_beats[$];  // results still owed by the block

  // allocated chains the traffic generator still owns
  int        owned_blk[$];

  int        n_fail;
  int        beats_done;
  int        cycles;
  bit        calm;              // no idle gaps while set

  function automatic cmd_beat_t op(cmd_e_t c, int len, int dat, int blk);
    cmd_beat_t b;
    b.cmd         = c;
    b.msg_length  = LEN_W'(len);
    b.data_byte   = BYTE_W'(dat);
    b.first_block = BLK_W'(blk);
    return b;
  endfunction

  function automatic rsp_beat_t ans(kind_e_t k, status_e_t s, int blk, int fc,
                                    int by, bit lst);
    rsp_beat_t r;
    r.kind        = k;
    r.status      = s;
    r.chain_start = BLK_W'(blk);
    r.free_blocks = CNT_W'(fc);
    r.byte_out    = BYTE_W'(by);
    r.last        = lst;
    return r;
  endfunction

  function automatic dir_row_t row(cmd_beat_t b, bit t, rsp_beat_t w);
    dir_row_t d;
    d.beat  = b;
    d.typed = t;
    d.want  = w;
    return d;
  endfunction

  // take one block number off the head of the free ring
  function automatic int pop_free();
    int blk;
    blk      = int'(ring_q[ring_rd]);
    ring_rd  = (ring_rd == NUM_BLOCKS - 1) ? 0 : ring_rd + 1;
    free_cnt = free_cnt - 1;
    return blk;
  endfunction

  // Apply one command beat to the pool model; results land in step_beats.
  task automatic pool_apply(input cmd_beat_t b);
    int len;
    int need;
    int head;
    int cur;
    int nb;
    int n;
    int steps;
    int lim;
    int cnt;
    int off;
    int addr;
    len = int'(b.msg_length);
    step_beats.delete();
    case (b.cmd)
      CMD_CREATE: begin
        need = (len + BLOCK_SIZE - 1) / BLOCK_SIZE;
        if (need == 0) need = 1;   // an empty message still owns a block
        if (len > POOL_BYTES) begin
          step_beats.push_back(ans(KIND_CREATE, ST_TOO_LONG, 0, free_cnt, 0, 1'b1));
        end else if (need > free_cnt) begin
          step_beats.push_back(ans(KIND_CREATE, ST_NO_BLOCKS, 0, free_cnt, 0, 1'b1));
        end else begin
          head = pop_free();
          cur  = head;
          for (n = 1; n < need; n++) begin
            nb           = pop_free();
            link_q[cur]  = LINK_W'(nb);
            linked_q[cur] = 1'b1;
            cur          = nb;
          end
          link_q[cur]   = LINK_END;
          linked_q[cur] = 1'b1;
          // a new message drops whatever was left unfilled of the old one
          fill_blk  = head;
          fill_off  = 0;
          fill_left = len;
          step_beats.push_back(ans(KIND_CREATE, ST_OK, head, free_cnt, 0, 1'b1));
        end
      end
      CMD_DATA: begin
        if (fill_left != 0) begin
          addr            = fill_blk * BLOCK_SIZE + fill_off;
          store_q[addr]   = b.data_byte;
          written_q[addr] = 1'b1;
          fill_left       = fill_left - 1;
          fill_off        = fill_off + 1;
          if (fill_off >= BLOCK_SIZE) begin
            fill_off = 0;
            cur      = int'(link_q[fill_blk]);
            if (cur >= NUM_BLOCKS) fill_left = 0;
            else fill_blk = cur;
          end
        end
      end
      CMD_FREE: begin
        cur   = int'(b.first_block);
        steps = 0;
        // stops at chain end, at a full pool, or after one lap of the pool
        while (cur < NUM_BLOCKS && free_cnt < NUM_BLOCKS && steps < NUM_BLOCKS) begin
          ring_wr         = (ring_wr == NUM_BLOCKS - 1) ? 0 : ring_wr + 1;
          ring_q[ring_wr] = BLK_W'(cur);
          free_cnt        = free_cnt + 1;
          steps           = steps + 1;
          cur             = int'(link_q[cur]);
        end
        step_beats.push_back(ans(KIND_FREE, ST_OK, 0, free_cnt, 0, 1'b1));
      end
      default: begin
        lim = len;
        if (lim > POOL_BYTES) lim = POOL_BYTES;
        if (lim > MAX_OUT) lim = MAX_OUT;
        cnt = 0;
        off = 0;
        cur = int'(b.first_block);
        while (cnt < lim && cur < NUM_BLOCKS) begin
          step_beats.push_back(ans(KIND_READ, ST_OK, 0, 0,
                                   int'(store_q[cur * BLOCK_SIZE + off]), 1'b0));
          cnt = cnt + 1;
          off = off + 1;
          if (off >= BLOCK_SIZE) begin
            off = 0;
            cur = int'(link_q[cur]);
          end
        end
        if (cnt > 0) step_beats[cnt - 1].last = 1'b1;
      end
    endcase
  endtask

  // Longest read length up to len that only touches written bytes.
  function automatic int read_fit(int blk, int len);
    int lim;
    int cnt;
    int off;
    int cur;
    lim = (len > READ_LIMIT) ? READ_LIMIT : len;
    cnt = 0;
    off = 0;
    cur = blk;
    while (cnt < lim && cur < NUM_BLOCKS) begin
      if (!written_q[cur * BLOCK_SIZE + off]) return cnt;
      cnt = cnt + 1;
      off = off + 1;
      if (off == BLOCK_SIZE) begin
        off = 0;
        cur = int'(link_q[cur]);
      end
    end
    return len;
  endfunction

  // Present one command beat, hold it until the block takes it, then book the
  // expected results. A typed row replaces the model's answer by its own.
  task automatic issue(input cmd_beat_t b, input bit typed, input rsp_beat_t want);
    int  gap;
    bit  stray;
    if (!calm && $urandom_range(99) < 12) begin
      gap = $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= b;
    do @(posedge clk); while (!(start === 1'b1 && busy === 1'b0));
    stray = (b.cmd == CMD_DATA && fill_left == 0);
    pool_apply(b);
    if (typed) begin
      awaited_beats.push_back(want);
    end else begin
      foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
    end
    // stray bytes and zero-length reads do nothing; they are not counted
    if (!stray && !(b.cmd == CMD_READ && step_beats.size() == 0))
      beats_done = beats_done + 1;
  endtask

  task automatic free_oldest();
    int blk;
    blk = owned_blk.pop_front();
    issue(op(CMD_FREE, $urandom_range(255), $urandom_range(255), blk), 1'b0, UNTYPED);
  endtask

  // One message: create, fill, maybe read back, maybe hand back.
  task automatic send_message();
    int r;
    int len;
    int need;
    int nb;
    int blk;
    int rlen;
    r = $urandom_range(99);
    if (r < 60) len = $urandom_range(12);
    else if (r < 85) len = $urandom_range(40, 13);
    else if (r < 95) len = $urandom_range(64, 41);
    else len = $urandom_range(255, 65);
    need = (len + BLOCK_SIZE - 1) / BLOCK_SIZE;
    if (need == 0) need = 1;
    // usually make room first; sometimes let the create be refused
    while (owned_blk.size() > 0 && need > free_cnt && $urandom_range(3) != 0)
      free_oldest();
    issue(op(CMD_CREATE, len, $urandom_range(255), $urandom_range(15)), 1'b0, UNTYPED);
    if (step_beats[0].status != ST_OK) return;
    blk = int'(step_beats[0].chain_start);
    // now and then the message is cut short and the rest dropped later
    nb = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
    repeat (nb)
      issue(op(CMD_DATA, $urandom_range(255), $urandom_range(255), $urandom_range(15)),
            1'b0, UNTYPED);
    if ($urandom_range(3) != 0) begin
      r = $urandom_range(9);
      if (r < 5) rlen = len;
      else if (r < 8) rlen = $urandom_range(255);
      else rlen = len + $urandom_range(8);
      if (rlen > 255) rlen = 255;
      rlen = read_fit(blk, rlen);
      issue(op(CMD_READ, rlen, $urandom_range(255), blk), 1'b0, UNTYPED);
    end
    owned_blk.push_back(blk);
    if ($urandom_range(1) == 0) free_oldest();
  endtask

  // Off-pattern traffic: stray bytes, random creates, reads of stale
  // chains, frees of any chain (double frees included).
  task automatic send_noise();
    int pick;
    int blk;
    int tries;
    pick = $urandom_range(3);
    blk  = $urandom_range(15);
    tries = 0;
    while (!linked_q[blk] && tries < NUM_BLOCKS) begin
      blk   = (blk + 1) % NUM_BLOCKS;
      tries = tries + 1;
    end
    if (!linked_q[blk] && pick >= 2) pick = 1;
    case (pick)
      0: issue(op(CMD_DATA, $urandom_range(255), $urandom_range(255), $urandom_range(15)),
               1'b0, UNTYPED);
      1: issue(op(CMD_CREATE, $urandom_range(255), $urandom_range(255),
                  $urandom_range(15)), 1'b0, UNTYPED);
      2: issue(op(CMD_READ, read_fit(blk, $urandom_range(255)), $urandom_range(255), blk),
               1'b0, UNTYPED);
      default: issue(op(CMD_FREE, $urandom_range(255), $urandom_range(255), blk),
                     1'b0, UNTYPED);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random traffic, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab[$];

    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    calm    = 1'b0;
    n_fail  = 0;
    beats_done = 0;

    // model after reset: ring slot k holds k, everything free
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      ring_q[k]   = BLK_W'(k);
      linked_q[k] = 1'b0;
    end
    for (int k = 0; k < POOL_BYTES; k++) written_q[k] = 1'b0;
    ring_rd   = 0;
    ring_wr   = NUM_BLOCKS - 1;
    free_cnt  = NUM_BLOCKS;
    fill_blk  = 0;
    fill_off  = 0;
    fill_left = 0;

    // Directed table. Typed answers follow from the ring order after reset.
    // too long: just over capacity, and the largest length
    dir_tab.push_back(row(op(CMD_CREATE, 65, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_TOO_LONG, 0, 16, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_CREATE, 255, 255, 15), 1'b1,
                          ans(KIND_CREATE, ST_TOO_LONG, 0, 16, 0, 1'b1)));
    // byte with nothing pending: ignored
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h3C, 0), 1'b0, UNTYPED));
    // empty message still takes one block
    dir_tab.push_back(row(op(CMD_CREATE, 0, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_OK, 0, 15, 0, 1'b1)));
    // zero-length read: no beat at all
    dir_tab.push_back(row(op(CMD_READ, 0, 0, 0), 1'b0, UNTYPED));
    // whole pool asked for with one block gone
    dir_tab.push_back(row(op(CMD_CREATE, 64, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_NO_BLOCKS, 0, 15, 0, 1'b1)));
    // five bytes over two blocks, extreme byte values
    dir_tab.push_back(row(op(CMD_CREATE, 5, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_OK, 1, 13, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h00, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'hFF, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h5A, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'hA5, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h81, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_READ, 5, 0, 1), 1'b0, UNTYPED));
    // create while bytes pending drops the unfilled rest
    dir_tab.push_back(row(op(CMD_CREATE, 8, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_OK, 3, 11, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h11, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h22, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_CREATE, 4, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_OK, 5, 10, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'hFE, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_DATA, 0, 8'h01, 0), 1'b0, UNTYPED));
    dir_tab.push_back(row(op(CMD_READ, 2, 0, 5), 1'b0, UNTYPED));
    // hand everything back; the last free hits a full pool
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 1), 1'b1, ans(KIND_FREE, ST_OK, 0, 12, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 0), 1'b1, ans(KIND_FREE, ST_OK, 0, 13, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 3), 1'b1, ans(KIND_FREE, ST_OK, 0, 15, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 5), 1'b1, ans(KIND_FREE, ST_OK, 0, 16, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 5), 1'b1, ans(KIND_FREE, ST_OK, 0, 16, 0, 1'b1)));
    // whole pool in one chain, then an empty pool, then a 16-block free
    dir_tab.push_back(row(op(CMD_CREATE, 64, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_OK, 6, 0, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_CREATE, 0, 0, 0), 1'b1,
                          ans(KIND_CREATE, ST_NO_BLOCKS, 0, 0, 0, 1'b1)));
    dir_tab.push_back(row(op(CMD_FREE, 0, 0, 6), 1'b1, ans(KIND_FREE, ST_OK, 0, 16, 0, 1'b1)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) issue(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    // random traffic, mostly well-formed messages; one long gap-free stretch
    while (beats_done < TARGET_BEATS) begin
      calm = (beats_done >= 110 && beats_done < 180);
      if ($urandom_range(99) < 70) send_message();
      else send_noise();
    end
    calm = 1'b0;

    start <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: every valid beat is taken, matched against the oldest
  // expectation. The receiver has no back-pressure, so nothing to drive here.
  // --------------------------------------------------------------------------
  task automatic check_field(input string nm, input logic [7:0] w, input logic [7:0] g);
    if (g !== w) begin
      $error("%s: expected %0d, got %0d", nm, w, g);
      n_fail = n_fail + 1;
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_beat_t w;
    if (!rst && valid === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail = n_fail + 1;
      end else begin
        w = awaited_beats.pop_front();
        check_field("kind",        8'(w.kind),        8'(result.kind));
        check_field("status",      8'(w.status),      8'(result.status));
        check_field("chain_start", 8'(w.chain_start), 8'(result.chain_start));
        check_field("free_blocks", 8'(w.free_blocks), 8'(result.free_blocks));
        check_field("byte_out",    w.byte_out,        result.byte_out);
        check_field("last",        8'(w.last),        8'(result.last));
      end
    end else if (!rst && valid !== 1'b0) begin
      $error("valid is unknown");
      n_fail = n_fail + 1;
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
